// ----- rtl/core/vpp_pkg.sv -----
package vpp_pkg;

	// internal coordinates are Q.8
	localparam int VW   = 20;  // vertex / camera coordinate
	localparam int DVW  = 21;  // vertex minus camera
	localparam int CPW  = 40;  // single camera-vertex product
	localparam int CVW  = 41;  // dot product C.V
	localparam int KW   = 40;  // K = C.C, unsigned
	localparam int KH   = 20;  // K is split in two halves for the numerator
	localparam int DENW = 42;  // K - C.V
	localparam int PPW  = 42;  // numerator partial product
	localparam int NUMW = 62;  // numerator (V-C)*K
	localparam int DW   = 41;  // divisor magnitude
	localparam int NW   = 61;  // rounded dividend magnitude
	localparam int QB   = 41;  // quotient bits, one per divider stage
	localparam int CW   = 42;  // clamped coordinate, +-2^40
	localparam int PRW  = 58;  // coordinate times trig value

	typedef logic signed [15:0]   trig_t;
	typedef logic signed [CW-1:0] coord_t;

	typedef enum logic [2:0] {
		REG_COS_X = 3'd0,
		REG_SIN_X = 3'd1,
		REG_COS_Y = 3'd2,
		REG_SIN_Y = 3'd3,
		REG_COS_Z = 3'd4,
		REG_SIN_Z = 3'd5,
		REG_DIST  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		trig_t       cos_x;
		trig_t       sin_x;
		trig_t       cos_y;
		trig_t       sin_y;
		trig_t       cos_z;
		trig_t       sin_z;
		logic [14:0] distance;
	} cfg_t;

	// camera terms, trig values already clamped to +-1.0
	typedef struct packed {
		logic signed [VW-1:0] c0;
		logic signed [VW-1:0] c1;
		logic signed [VW-1:0] c2;
		logic [KW-1:0]        k;
		trig_t                cos_x;
		trig_t                sin_x;
		trig_t                cos_y;
		trig_t                sin_y;
		trig_t                cos_z;
		trig_t                sin_z;
	} cam_t;

	typedef struct packed {
		logic [DW-1:0]        ud;
		logic [2:0][NW-1:0]   n;
		logic [2:0]           neg;
		logic                 degen;
	} div_req_t;

	typedef struct packed {
		logic [2:0][QB-1:0]   q;
		logic [2:0]           neg;
		logic                 degen;
	} div_rsp_t;

endpackage

// ----- rtl/core/vpp_camera.sv -----
module vpp_camera
	import vpp_pkg::*;
(
	input  logic clk,
	input  cfg_t cfg,
	output cam_t cam
);

	localparam trig_t ONE = 16'sd16384;

	function automatic trig_t clamp_trig(input trig_t v);
		if (v > ONE) return ONE;
		if (v < -ONE) return -ONE;
		return v;
	endfunction

	trig_t cx, sx, cy, sy, cz, sz;
	trig_t cx_s1, sx_s1, cy_s1, sy_s1, cz_s1, sz_s1;
	logic [14:0] dist_s1;
	logic signed [31:0] nsxcy_s1, cxcy_s1, syd_s1;
	logic signed [47:0] t1_s2, t2_s2;
	logic signed [VW-1:0] c0_s2, c0_s3, c1_s3, c2_s3;
	logic [KW-1:0] sq0_s4, sq1_s4, sq2_s4;
	logic [KW-1:0] k_s5;

	assign cx = clamp_trig(cfg.cos_x);
	assign sx = clamp_trig(cfg.sin_x);
	assign cy = clamp_trig(cfg.cos_y);
	assign sy = clamp_trig(cfg.sin_y);
	assign cz = clamp_trig(cfg.cos_z);
	assign sz = clamp_trig(cfg.sin_z);

	// free running: settles after any register write
	always_ff @(posedge clk) begin
		cx_s1    <= cx;
		sx_s1    <= sx;
		cy_s1    <= cy;
		sy_s1    <= sy;
		cz_s1    <= cz;
		sz_s1    <= sz;
		dist_s1  <= cfg.distance;
		nsxcy_s1 <= -(sx * cy);
		cxcy_s1  <= cx * cy;
		syd_s1   <= sy * $signed({1'b0, cfg.distance});

		c0_s2 <= VW'((syd_s1 + 32'sd512) >>> 10);
		t1_s2 <= nsxcy_s1 * $signed({1'b0, dist_s1});
		t2_s2 <= cxcy_s1 * $signed({1'b0, dist_s1});

		c0_s3 <= c0_s2;
		c1_s3 <= VW'((t1_s2 + 48'sd8388608) >>> 24);
		c2_s3 <= VW'((t2_s2 + 48'sd8388608) >>> 24);

		sq0_s4 <= KW'(c0_s3 * c0_s3);
		sq1_s4 <= KW'(c1_s3 * c1_s3);
		sq2_s4 <= KW'(c2_s3 * c2_s3);

		k_s5 <= sq0_s4 + sq1_s4 + sq2_s4;
	end

	always_comb begin
		cam.c0    = c0_s3;
		cam.c1    = c1_s3;
		cam.c2    = c2_s3;
		cam.k     = k_s5;
		cam.cos_x = cx_s1;
		cam.sin_x = sx_s1;
		cam.cos_y = cy_s1;
		cam.sin_y = sy_s1;
		cam.cos_z = cz_s1;
		cam.sin_z = sz_s1;
	end

endmodule

// ----- rtl/core/vpp_front.sv -----
module vpp_front
	import vpp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [2:0][15:0] vtx,
	input  cam_t            cam,
	output logic            out_valid,
	input  logic            out_ready,
	output div_req_t        req
);

	localparam int NS = 9;

	logic [NS:1] vld_q;
	logic [NS:1] rdy;

	logic signed [VW-1:0]   cam_c [3];
	logic signed [VW-1:0]   v_s1 [3];
	logic signed [VW-1:0]   v_s2 [3];
	logic signed [VW-1:0]   v_s3 [3];
	logic signed [CPW-1:0]  cvp_s4 [3];
	logic signed [DVW-1:0]  dv_s4 [3];
	logic signed [DVW-1:0]  dv_s5 [3];
	logic signed [CVW-1:0]  cv_s5;
	logic signed [DENW-1:0] den_s6, den_s7;
	logic signed [PPW-1:0]  pl_s6 [3];
	logic signed [PPW-1:0]  ph_s6 [3];
	logic signed [NUMW-1:0] num_s7 [3];
	logic [DW-1:0]          ud_s8, ud_s9;
	logic [NW-1:0]          un_s8 [3];
	logic [NW-1:0]          n_s9 [3];
	logic [2:0]             neg_s8, neg_s9;
	logic                   degen_s8, degen_s9;

	assign cam_c[0] = cam.c0;
	assign cam_c[1] = cam.c1;
	assign cam_c[2] = cam.c2;

	assign rdy[NS] = !vld_q[NS] || out_ready;
	for (genvar k = 1; k < NS; k++) begin : g_rdy
		assign rdy[k] = !vld_q[k] || rdy[k+1];
	end

	assign in_ready  = rdy[1];
	assign out_valid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_q & ~rdy) | ({vld_q[NS-1:1], in_valid} & rdy);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (rdy[1]) v_s1[i] <= $signed({vtx[i], 4'b0000});
			if (rdy[2]) v_s2[i] <= v_s1[i];
			if (rdy[3]) v_s3[i] <= v_s2[i];
			if (rdy[4]) begin
				cvp_s4[i] <= cam_c[i] * v_s3[i];
				dv_s4[i]  <= DVW'(v_s3[i]) - DVW'(cam_c[i]);
			end
			if (rdy[5]) dv_s5[i] <= dv_s4[i];
			if (rdy[6]) begin
				pl_s6[i] <= dv_s5[i] * $signed({1'b0, cam.k[KH-1:0]});
				ph_s6[i] <= dv_s5[i] * $signed({1'b0, cam.k[KW-1:KH]});
			end
			if (rdy[7]) num_s7[i] <= (NUMW'(ph_s6[i]) <<< KH) + NUMW'(pl_s6[i]);
			if (rdy[8]) begin
				un_s8[i]  <= NW'(num_s7[i][NUMW-1] ? -num_s7[i] : num_s7[i]);
				neg_s8[i] <= num_s7[i][NUMW-1] ^ den_s7[DENW-1];
			end
			// round half away from zero on magnitudes
			if (rdy[9]) n_s9[i] <= un_s8[i] + NW'(ud_s8 >> 1);
		end
		if (rdy[5]) cv_s5 <= CVW'(cvp_s4[0]) + CVW'(cvp_s4[1]) + CVW'(cvp_s4[2]);
		if (rdy[6]) den_s6 <= DENW'($signed({1'b0, cam.k})) - DENW'(cv_s5);
		if (rdy[7]) den_s7 <= den_s6;
		if (rdy[8]) begin
			ud_s8    <= DW'(den_s7[DENW-1] ? -den_s7 : den_s7);
			degen_s8 <= (den_s7 == '0);
		end
		if (rdy[9]) begin
			ud_s9    <= ud_s8;
			neg_s9   <= neg_s8;
			degen_s9 <= degen_s8;
		end
	end

	always_comb begin
		req.ud    = ud_s9;
		req.neg   = neg_s9;
		req.degen = degen_s9;
		for (int i = 0; i < 3; i++) begin
			req.n[i] = n_s9[i];
		end
	end

endmodule

// ----- rtl/core/vpp_divider.sv -----
module vpp_divider
	import vpp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  div_req_t req,
	output logic     out_valid,
	input  logic     out_ready,
	output div_rsp_t rsp
);

	// restoring division, one quotient bit per stage, three lanes sharing the divisor
	logic [QB-1:0] vld_q;
	logic [QB-1:0] rdy;

	logic [NW-1:0] rem_s [QB-1][3];
	logic [QB-1:0] quo_s [QB][3];
	logic [DW-1:0] dvs_s [QB-1];
	logic [2:0]    sat_s [QB];
	logic [2:0]    neg_s [QB];
	logic [QB-1:0] degen_s;

	assign rdy[QB-1] = !vld_q[QB-1] || out_ready;
	for (genvar k = 0; k < QB-1; k++) begin : g_rdy
		assign rdy[k] = !vld_q[k] || rdy[k+1];
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_q[QB-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_q & ~rdy) | ({vld_q[QB-2:0], in_valid} & rdy);
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int B = QB-1-k;

		logic [NW-1:0] r_in [3];
		logic [QB-1:0] q_in [3];
		logic [2:0]    sat_in;
		logic [2:0]    neg_in;
		logic          dg_in;
		logic [DW-1:0] d_in;
		logic [2:0]    take;

		if (k == 0) begin : g_first
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					r_in[i]   = req.n[i];
					q_in[i]   = '0;
					// quotient would not fit: the coordinate clamps anyway
					sat_in[i] = (req.n[i] >> QB) >= NW'(req.ud);
				end
				neg_in = req.neg;
				dg_in  = req.degen;
				d_in   = req.ud;
			end
		end else begin : g_next
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					r_in[i] = rem_s[k-1][i];
					q_in[i] = quo_s[k-1][i];
				end
				sat_in = sat_s[k-1];
				neg_in = neg_s[k-1];
				dg_in  = degen_s[k-1];
				d_in   = dvs_s[k-1];
			end
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				take[i] = (r_in[i] >> B) >= NW'(d_in);
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				for (int i = 0; i < 3; i++) begin
					quo_s[k][i] <= q_in[i] | (QB'(take[i]) << B);
				end
				sat_s[k]   <= sat_in;
				neg_s[k]   <= neg_in;
				degen_s[k] <= dg_in;
			end
		end

		if (k < QB-1) begin : g_rem
			always_ff @(posedge clk) begin
				if (rdy[k]) begin
					for (int i = 0; i < 3; i++) begin
						rem_s[k][i] <= take[i] ? r_in[i] - (NW'(d_in) << B) : r_in[i];
					end
					dvs_s[k] <= d_in;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rsp.q[i] = sat_s[QB-1][i] ? '1 : quo_s[QB-1][i];
		end
		rsp.neg   = neg_s[QB-1];
		rsp.degen = degen_s[QB-1];
	end

endmodule

// ----- rtl/core/vpp_back.sv -----
module vpp_back
	import vpp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  div_rsp_t           rsp,
	input  cam_t               cam,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] view_x,
	output logic signed [15:0] view_y,
	output logic               degen
);

	localparam int NS  = 8;
	localparam int SW  = 60;
	localparam int CW1 = CW + 1;
	localparam logic signed [SW-1:0] BIG = 60'sd1 <<< 40;

	function automatic coord_t clamp_big(input logic signed [SW-1:0] v);
		if (v > BIG) return CW'(BIG);
		if (v < -BIG) return CW'(-BIG);
		return CW'(v);
	endfunction

	function automatic coord_t rot(input logic signed [PRW-1:0] a,
		input logic signed [PRW-1:0] b);
		logic signed [SW-1:0] s;
		s = SW'(a) + SW'(b) + 60'sd8192;
		return clamp_big(s >>> 14);
	endfunction

	function automatic logic signed [15:0] to_screen(input coord_t v);
		logic signed [CW1-1:0] r;
		r = (CW1'(v) + 43'sd8) >>> 4;
		if (r > 43'sd32767) return 16'sh7fff;
		if (r < -43'sd32768) return 16'sh8000;
		return 16'(r);
	endfunction

	logic [NS:1] vld_q;
	logic [NS:1] rdy;

	logic signed [VW-1:0] cam_c [3];
	trig_t nsx, nsy, nsz;

	coord_t p_s1 [3];
	logic signed [PRW-1:0] m_s2 [4];
	coord_t p0_s2, p0_s3;
	coord_t y1_s3, z1_s3;
	logic signed [PRW-1:0] m_s4 [2];
	coord_t y1_s4, y1_s5, x1_s5;
	logic signed [PRW-1:0] m_s6 [4];
	coord_t ox_s7, oy_s7;
	logic signed [15:0] sx_s8, sy_s8;
	logic [NS:1] dg_s;

	assign cam_c[0] = cam.c0;
	assign cam_c[1] = cam.c1;
	assign cam_c[2] = cam.c2;
	assign nsx = -cam.sin_x;
	assign nsy = -cam.sin_y;
	assign nsz = -cam.sin_z;

	assign rdy[NS] = !vld_q[NS] || out_ready;
	for (genvar k = 1; k < NS; k++) begin : g_rdy
		assign rdy[k] = !vld_q[k] || rdy[k+1];
	end

	assign in_ready  = rdy[1];
	assign out_valid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_q & ~rdy) | ({vld_q[NS-1:1], in_valid} & rdy);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i] <= clamp_big(rsp.neg[i] ?
					SW'(cam_c[i]) - $signed(SW'(rsp.q[i])) :
					SW'(cam_c[i]) + $signed(SW'(rsp.q[i])));
			end
			dg_s[1] <= rsp.degen;
		end
		// rotate back about x
		if (rdy[2]) begin
			m_s2[0] <= p_s1[1] * cam.cos_x;
			m_s2[1] <= p_s1[2] * cam.sin_x;
			m_s2[2] <= p_s1[1] * nsx;
			m_s2[3] <= p_s1[2] * cam.cos_x;
			p0_s2   <= p_s1[0];
			dg_s[2] <= dg_s[1];
		end
		if (rdy[3]) begin
			y1_s3   <= rot(m_s2[0], m_s2[1]);
			z1_s3   <= rot(m_s2[2], m_s2[3]);
			p0_s3   <= p0_s2;
			dg_s[3] <= dg_s[2];
		end
		// about y
		if (rdy[4]) begin
			m_s4[0] <= p0_s3 * cam.cos_y;
			m_s4[1] <= z1_s3 * nsy;
			y1_s4   <= y1_s3;
			dg_s[4] <= dg_s[3];
		end
		if (rdy[5]) begin
			x1_s5   <= rot(m_s4[0], m_s4[1]);
			y1_s5   <= y1_s4;
			dg_s[5] <= dg_s[4];
		end
		// about z
		if (rdy[6]) begin
			m_s6[0] <= x1_s5 * cam.cos_z;
			m_s6[1] <= y1_s5 * cam.sin_z;
			m_s6[2] <= x1_s5 * nsz;
			m_s6[3] <= y1_s5 * cam.cos_z;
			dg_s[6] <= dg_s[5];
		end
		if (rdy[7]) begin
			ox_s7   <= rot(m_s6[0], m_s6[1]);
			oy_s7   <= rot(m_s6[2], m_s6[3]);
			dg_s[7] <= dg_s[6];
		end
		if (rdy[8]) begin
			sx_s8   <= dg_s[7] ? '0 : to_screen(ox_s7);
			sy_s8   <= dg_s[7] ? '0 : to_screen(oy_s7);
			dg_s[8] <= dg_s[7];
		end
	end

	assign view_x = sx_s8;
	assign view_y = sy_s8;
	assign degen  = dg_s[NS];

endmodule

// ----- rtl/core/vertex_plane_projection.sv -----
// Projects one Q12.4 world vertex per clock, unless the output holds it off,
// onto the plane through the origin normal to the camera vector, then rotates
// it back by the camera angles into Q12.4 screen coordinates (saturated); a ray
// parallel to the plane gives tuser = 1 with zero coordinates. A new vertex can
// be taken every cycle unless stalled; each vertex passes 9 set-up stages, 41
// stages of the bit-per-stage divider and 8 rotation and output stages.
// Each stage accepts while empty, so a waiting result holds off new vertices
// only once the pipe is full. Camera terms are derived from the registers in
// a 5-stage chain; write registers only while no vertex is in flight.
module vertex_plane_projection
	import vpp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// vertex in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // vertex_x, vertex_y, vertex_z
	// screen point out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // view_x, view_y
	output logic [0:0]  m_axis_tuser   // degenerate
);

	localparam cfg_t CFG_RESET = '{
		cos_x: 16'sd16384, sin_x: 16'sd0,
		cos_y: 16'sd16384, sin_y: 16'sd0,
		cos_z: 16'sd16384, sin_z: 16'sd0,
		distance: 15'd4000
	};

	cfg_t     cfg_q;
	cam_t     cam;
	logic     wr_en;
	reg_idx_t idx;

	logic     f_valid, f_ready;
	div_req_t f_req;
	logic     d_valid, d_ready;
	div_rsp_t d_rsp;
	logic signed [15:0] view_x, view_y;
	logic     degen;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_COS_X: cfg_q.cos_x    <= pwdata[15:0];
				REG_SIN_X: cfg_q.sin_x    <= pwdata[15:0];
				REG_COS_Y: cfg_q.cos_y    <= pwdata[15:0];
				REG_SIN_Y: cfg_q.sin_y    <= pwdata[15:0];
				REG_COS_Z: cfg_q.cos_z    <= pwdata[15:0];
				REG_SIN_Z: cfg_q.sin_z    <= pwdata[15:0];
				REG_DIST:  cfg_q.distance <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_COS_X: prdata = 32'(cfg_q.cos_x);
			REG_SIN_X: prdata = 32'(cfg_q.sin_x);
			REG_COS_Y: prdata = 32'(cfg_q.cos_y);
			REG_SIN_Y: prdata = 32'(cfg_q.sin_y);
			REG_COS_Z: prdata = 32'(cfg_q.cos_z);
			REG_SIN_Z: prdata = 32'(cfg_q.sin_z);
			REG_DIST:  prdata = 32'(cfg_q.distance);
			default:   prdata = '0;
		endcase
	end

	vpp_camera u_camera (
		.clk (clk),
		.cfg (cfg_q),
		.cam (cam)
	);

	vpp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.vtx       (s_axis_tdata),
		.cam       (cam),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.req       (f_req)
	);

	vpp_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.req       (f_req),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.rsp       (d_rsp)
	);

	vpp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d_valid),
		.in_ready  (d_ready),
		.rsp       (d_rsp),
		.cam       (cam),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.view_x    (view_x),
		.view_y    (view_y),
		.degen     (degen)
	);

	assign m_axis_tdata = {view_y, view_x};
	assign m_axis_tuser = degen;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("degenerate beat with nonzero coordinates");

	// an empty output stage means no stage anywhere can hold off the input
	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output stage empty");

	a_mid_flow: assert property (@(posedge clk) disable iff (!arst_n)
		f_valid && !f_ready |-> d_valid)
		else $error("front stalled while divider output empty");

endmodule

// ----- tb/vertex_plane_projection_test.sv -----
module vertex_plane_projection_test;
	import vpp_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int STALL_LIMIT = 3000;
	localparam int PIPE_DRAIN = 70;

	typedef struct {
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic               degen;
	} screen_pt_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;  // vertex_x, vertex_y, vertex_z
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;  // view_x, view_y
	logic [0:0]  m_axis_tuser;  // degenerate

	// shadow of the register file
	logic signed [15:0] trig_reg[6];
	logic [14:0]        dist_reg;

	screen_pt_t pending_pts[$];
	int         errors;
	int         idle_cycles;
	int         burst_left;
	int         hold_requests;
	int         holds_seen;
	int         hold_left;
	int         rx_mode;
	int         rx_mode_left;

	vertex_plane_projection u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic longint round_sh(longint a, int s);
		return (a + (64'sd1 << (s - 1))) >>> s;
	endfunction

	function automatic longint lim(longint a, longint lo, longint hi);
		return a < lo ? lo : (a > hi ? hi : a);
	endfunction

	function automatic longint big_lim(longint a);
		return lim(a, -(64'sd1 <<< 40), 64'sd1 <<< 40);
	endfunction

	function automatic longint rotate(longint a, longint ka, longint b, longint kb);
		return big_lim(round_sh(a * ka + b * kb, 14));
	endfunction

	// nearest, ties away from zero
	function automatic longint div_nearest(longint num, longint den);
		longint unsigned un, ud, q;
		longint r;
		un = num < 0 ? -num : num;
		ud = den < 0 ? -den : den;
		q = (un + ud / 2) / ud;
		r = q > 64'h7fff_ffff_ffff_ffff ? 64'sh7fff_ffff_ffff_ffff : longint'(q);
		return ((num < 0) != (den < 0)) ? -r : r;
	endfunction

	function automatic screen_pt_t project_vertex(logic [47:0] vtx);
		longint cx, sx, cy, sy, cz, sz, d, k, cv, den, y1, z1, x1, ox, oy;
		longint cam[3], v[3], p[3];
		screen_pt_t r;
		cx = lim(trig_reg[REG_COS_X], -16384, 16384);
		sx = lim(trig_reg[REG_SIN_X], -16384, 16384);
		cy = lim(trig_reg[REG_COS_Y], -16384, 16384);
		sy = lim(trig_reg[REG_SIN_Y], -16384, 16384);
		cz = lim(trig_reg[REG_COS_Z], -16384, 16384);
		sz = lim(trig_reg[REG_SIN_Z], -16384, 16384);
		d = longint'(dist_reg);
		cam[0] = round_sh(sy * d, 10);
		cam[1] = round_sh(-(sx * cy * d), 24);
		cam[2] = round_sh(cx * cy * d, 24);
		for (int i = 0; i < 3; i++)
			v[i] = longint'($signed(vtx[16*i +: 16])) * 16;
		k = cam[0] * cam[0] + cam[1] * cam[1] + cam[2] * cam[2];
		cv = cam[0] * v[0] + cam[1] * v[1] + cam[2] * v[2];
		den = k - cv;
		if (den == 0) begin
			r.sx = '0;
			r.sy = '0;
			r.degen = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++)
			p[i] = big_lim(cam[i] + div_nearest((v[i] - cam[i]) * k, den));
		y1 = rotate(p[1], cx, p[2], sx);
		z1 = rotate(p[1], -sx, p[2], cx);
		x1 = rotate(p[0], cy, z1, -sy);
		ox = rotate(x1, cz, y1, sz);
		oy = rotate(x1, -sz, y1, cz);
		r.sx = 16'(lim(round_sh(ox, 4), -32768, 32767));
		r.sy = 16'(lim(round_sh(oy, 4), -32768, 32767));
		r.degen = 1'b0;
		return r;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx < 6)
			trig_reg[idx] = value[15:0];
		else if (idx == REG_DIST)
			dist_reg = value[14:0];
	endtask

	// wait for all results, then let the camera chain settle
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_pts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_camera(logic [15:0] cx, logic [15:0] sx, logic [15:0] cy,
			logic [15:0] sy, logic [15:0] cz, logic [15:0] sz, logic [14:0] d);
		settle();
		write_reg(REG_COS_X, {{16{cx[15]}}, cx});
		write_reg(REG_SIN_X, {{16{sx[15]}}, sx});
		write_reg(REG_COS_Y, {{16{cy[15]}}, cy});
		write_reg(REG_SIN_Y, {{16{sy[15]}}, sy});
		write_reg(REG_COS_Z, {{16{cz[15]}}, cz});
		write_reg(REG_SIN_Z, {{16{sz[15]}}, sz});
		write_reg(REG_DIST, {17'($urandom), d});
		repeat (8) @(posedge clk);
	endtask

	task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {z, y, x};
		do @(posedge clk); while (!s_axis_tready);
		pending_pts.push_back(project_vertex({z, y, x}));
	endtask

	function automatic logic [15:0] rand_coord();
		if ($urandom_range(0, 9) < 7)
			return 16'($signed($urandom_range(0, 8192)) - 4096);
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] rand_trig();
		if ($urandom_range(0, 19) == 0)
			return 16'($urandom);
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	task automatic send_random(int count);
		for (int i = 0; i < count; i++)
			send_vertex(rand_coord(), rand_coord(), rand_coord());
	endtask

	task automatic test_default_camera();
		send_vertex(16'sd0, 16'sd0, 16'sd0);
		send_vertex(16'sd160, -16'sd320, 16'sd480);
		send_vertex(16'h7fff, 16'h7fff, 16'h7fff);
		send_vertex(16'h8000, 16'h8000, 16'h8000);
		send_vertex(16'h7fff, 16'h8000, 16'h0000);
		send_vertex(16'h8000, 16'h7fff, 16'h7fff);
		// vertex level with the camera: ray parallel to the plane
		send_vertex(16'sd100, -16'sd77, 16'sd4000);
		send_vertex(16'sd0, 16'sd0, 16'sd3999);
		send_vertex(16'sd0, 16'sd0, 16'sd4001);
		send_vertex(16'hffff, 16'h0001, 16'h5555);
		send_vertex(16'haaaa, 16'h5555, 16'haaaa);
	endtask

	task automatic test_extreme_cameras();
		// camera at the origin
		set_camera(16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 15'd0);
		send_vertex(16'sd500, 16'sd600, 16'sd700);
		send_vertex(16'h8000, 16'h7fff, 16'h0000);
		set_camera(-16'sd16384, 16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384,
			16'sd16384, 15'h7fff);
		send_vertex(16'h7fff, 16'h7fff, 16'h7fff);
		send_vertex(16'h8000, 16'h8000, 16'h8000);
		send_vertex(16'sd0, 16'sd0, 16'sd0);
		// trig values beyond +-1.0 are clamped
		set_camera(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
			15'h7fff);
		send_vertex(16'sd1234, -16'sd4321, 16'sd999);
		send_vertex(16'h8000, 16'h7fff, 16'h8000);
		set_camera(16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 15'd1);
		send_vertex(16'sd1, 16'sd1, 16'sd1);
		send_vertex(16'h7fff, 16'h0000, 16'h8000);
		settle();
		// unknown index must not disturb the registers
		write_reg(REG_UNUSED, 32'hffff_ffff);
		repeat (8) @(posedge clk);
		send_vertex(16'sd200, 16'sd300, -16'sd400);
	endtask

	task automatic test_random_cameras();
		set_camera(16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 15'd4000);
		send_random(250);
		for (int ph = 0; ph < 6; ph++) begin
			set_camera(rand_trig(), rand_trig(), rand_trig(), rand_trig(), rand_trig(),
				rand_trig(), ph == 0 ? 15'h7fff : 15'($urandom_range(0, 32767)));
			send_random(230);
		end
	endtask

	task automatic test_backpressure();
		hold_requests++;
		send_random(300);
	endtask

	// receiver: changing stall pattern, plus an occasional long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			holds_seen <= 0;
			hold_left <= 0;
			rx_mode <= 0;
			rx_mode_left <= 0;
		end else if (holds_seen != hold_requests) begin
			holds_seen <= hold_requests;
			hold_left <= 400;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode <= $urandom_range(0, 3);
				rx_mode_left <= $urandom_range(20, 150);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		screen_pt_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_pts.size() == 0) begin
				$error("unexpected beat: tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				want = pending_pts.pop_front();
				if (m_axis_tdata[15:0] !== want.sx) begin
					$error("view_x expected %0d got %0d", want.sx,
						$signed(m_axis_tdata[15:0]));
					errors++;
				end
				if (m_axis_tdata[31:16] !== want.sy) begin
					$error("view_y expected %0d got %0d", want.sy,
						$signed(m_axis_tdata[31:16]));
					errors++;
				end
				if (m_axis_tuser[0] !== want.degen) begin
					$error("degenerate expected %0b got %0b", want.degen, m_axis_tuser[0]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("vertex_plane_projection verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		errors = 0;
		idle_cycles = 0;
		burst_left = 0;
		hold_requests = 0;
		trig_reg[REG_COS_X] = 16'sd16384;
		trig_reg[REG_SIN_X] = 16'sd0;
		trig_reg[REG_COS_Y] = 16'sd16384;
		trig_reg[REG_SIN_Y] = 16'sd0;
		trig_reg[REG_COS_Z] = 16'sd16384;
		trig_reg[REG_SIN_Z] = 16'sd0;
		dist_reg = 15'd4000;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (8) @(posedge clk);

		test_default_camera();
		test_extreme_cameras();
		test_random_cameras();
		test_backpressure();

		settle();
		repeat (PIPE_DRAIN) @(posedge clk);
		if (errors == 0 && pending_pts.size() == 0)
			$display("vertex_plane_projection verification clean");
		else
			$display("vertex_plane_projection verification failed");
		$finish;
	end

endmodule
